FILE: rtl/cnlf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlf_pkg
// Shared types and constants of the nibble link framer: item and result
// layouts, result kinds, request codes and the front-to-back record.
// ----------------------------------------------------------------------------
package cnlf_pkg;

    localparam int CNLF_MAX_REPLY_BYTES = 8;
    localparam int CNLF_QUEUE_DEPTH     = 2;

    localparam int PAYLOAD_W = 64;
    localparam int NBYTES_W  = 4;
    localparam int ADDR_W    = 4;
    localparam int NIBBLE_W  = 4;
    localparam int TAG_W     = 3;

    localparam logic [7:0] CODE_IDENTIFY = 8'h01;
    localparam logic [7:0] CODE_MEASURE  = 8'h06;
    localparam logic [7:0] MSG_FLAG      = 8'h80;

    localparam int LEN_IDENTIFY = 8;
    localparam int LEN_MEASURE  = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       command;
        logic [7:0] req_code;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            tx_byte;
        logic [PAYLOAD_W-1:0]  payload;
        logic [NBYTES_W-1:0]   payload_bytes;
        logic                  packet_error;
        logic                  last;
    } t_result;

    typedef struct packed {
        t_kind                 kind;
        logic [NIBBLE_W-1:0]   code_nib;
        logic [ADDR_W-1:0]     addr;
        logic [PAYLOAD_W-1:0]  payload;
        logic [NBYTES_W-1:0]   nbytes;
        logic                  err;
    } t_rec;

endpackage
`default_nettype wire

FILE: rtl/cnlf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlf_front
// Accepts items, classifies start commands, assembles reply nibbles and
// hands one record per result-producing item to the queue.
// ----------------------------------------------------------------------------
module cnlf_front #(
    parameter int MAX_REPLY_BYTES = cnlf_pkg::CNLF_MAX_REPLY_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire cnlf_pkg::t_item             i_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [cnlf_pkg::ADDR_W-1:0] i_cfg_data,
    output logic                             o_rec_valid,
    output cnlf_pkg::t_rec                   o_rec
);

    localparam int NL = 2 * MAX_REPLY_BYTES;
    localparam int AW = 8 * MAX_REPLY_BYTES;
    localparam int IW = $clog2(NL);
    localparam int BW = $clog2(MAX_REPLY_BYTES + 1);
    localparam int CW = ((IW > BW) ? IW : BW) + 1;
    localparam int LEN_ID = (cnlf_pkg::LEN_IDENTIFY > MAX_REPLY_BYTES) ?
                            MAX_REPLY_BYTES : cnlf_pkg::LEN_IDENTIFY;
    localparam int LEN_MS = (cnlf_pkg::LEN_MEASURE > MAX_REPLY_BYTES) ?
                            MAX_REPLY_BYTES : cnlf_pkg::LEN_MEASURE;

    logic [cnlf_pkg::ADDR_W-1:0]  r_addr;
    logic                         r_receiving, n_receiving;
    logic [BW-1:0]                r_len, n_len;
    logic [IW-1:0]                r_idx, n_idx;
    logic [cnlf_pkg::TAG_W-1:0]   r_tag, n_tag;
    logic                         r_mismatch, n_mismatch;
    logic [AW-1:0]                r_asm, n_asm;

    logic [cnlf_pkg::TAG_W-1:0]   rx_tag;
    logic [AW-1:0]                asm_upd;
    logic                         mis_upd;
    logic                         done;

    assign rx_tag = i_item.rx_byte[6:4];
    assign mis_upd = (r_idx != '0) && (rx_tag != r_tag) || r_mismatch;
    assign done = (CW'(r_idx) + CW'(1)) >= (CW'(r_len) << 1);

    always_comb begin
        asm_upd = r_asm;
        for (int k = 0; k < NL; k++) begin
            if (r_idx == IW'(k)) begin
                asm_upd[4*k +: 4] = i_item.rx_byte[3:0];
            end
        end
    end

    always_comb begin
        n_receiving = r_receiving;
        n_len       = r_len;
        n_idx       = r_idx;
        n_tag       = r_tag;
        n_mismatch  = r_mismatch;
        n_asm       = r_asm;
        o_rec_valid = 1'b0;
        o_rec.kind     = cnlf_pkg::KIND_REJECT;
        o_rec.code_nib = i_item.req_code[3:0];
        o_rec.addr     = r_addr;
        o_rec.payload  = '0;
        o_rec.nbytes   = '0;
        o_rec.err      = 1'b0;
        if (i_accept) begin
            if (i_item.command == cnlf_pkg::CMD_START) begin
                o_rec_valid = 1'b1;
                if (i_item.req_code == cnlf_pkg::CODE_IDENTIFY ||
                    i_item.req_code == cnlf_pkg::CODE_MEASURE) begin
                    o_rec.kind  = cnlf_pkg::KIND_REQUEST;
                    n_receiving = 1'b1;
                    n_len       = (i_item.req_code == cnlf_pkg::CODE_IDENTIFY) ?
                                  BW'(LEN_ID) : BW'(LEN_MS);
                    n_idx       = '0;
                    n_tag       = '0;
                    n_mismatch  = 1'b0;
                    n_asm       = '0;
                end else begin
                    n_receiving = 1'b0;
                end
            end else if (r_receiving) begin
                n_asm      = asm_upd;
                n_mismatch = mis_upd;
                if (r_idx == '0) begin
                    n_tag = rx_tag;
                end
                if (done) begin
                    o_rec_valid   = 1'b1;
                    o_rec.kind    = cnlf_pkg::KIND_REPLY;
                    o_rec.payload = cnlf_pkg::PAYLOAD_W'(asm_upd);
                    o_rec.nbytes  = cnlf_pkg::NBYTES_W'(r_len);
                    o_rec.err     = mis_upd;
                    n_receiving   = 1'b0;
                    n_idx         = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_receiving <= 1'b0;
            r_len       <= '0;
            r_idx       <= '0;
            r_tag       <= '0;
            r_mismatch  <= 1'b0;
            r_asm       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_addr <= i_cfg_data;
            end
            r_receiving <= n_receiving;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_tag       <= n_tag;
            r_mismatch  <= n_mismatch;
            r_asm       <= n_asm;
        end
    end

    a_reply_ends_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && o_rec.kind == cnlf_pkg::KIND_REPLY) |=> !r_receiving)
        else $error("reception still active after reply record");

endmodule
`default_nettype wire

FILE: rtl/cnlf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlf_queue
// Short record queue between the front and back ends.
// ----------------------------------------------------------------------------
module cnlf_queue #(
    parameter int DEPTH = cnlf_pkg::CNLF_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire cnlf_pkg::t_rec  i_wr_data,
    input  wire logic            i_rd,
    output logic                 o_full,
    output logic                 o_empty,
    output cnlf_pkg::t_rec       o_rd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    cnlf_pkg::t_rec    r_slot [DEPTH];
    logic [PW-1:0]     r_wptr, r_rptr;
    logic [CNTW-1:0]   r_count;
    logic              do_wr, do_rd;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_slot[r_rptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("record offered to a full queue");

endmodule
`default_nettype wire

FILE: rtl/cnlf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlf_back
// Expands queued records into result items and holds the oldest result in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module cnlf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire cnlf_pkg::t_rec  i_q_data,
    output logic                 o_q_rd,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output cnlf_pkg::t_result    o_result
);

    logic                          r_out_valid, n_out_valid;
    cnlf_pkg::t_result             r_out, n_out;
    logic                          r_second, n_second;
    logic [cnlf_pkg::NIBBLE_W-1:0] r_code_nib, n_code_nib;
    logic                          can_load;

    assign can_load = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_second    = r_second;
        n_code_nib  = r_code_nib;
        o_q_rd      = 1'b0;
        if (can_load) begin
            n_out_valid = 1'b0;
            n_out.kind          = cnlf_pkg::KIND_REQUEST;
            n_out.tx_byte       = '0;
            n_out.payload       = '0;
            n_out.payload_bytes = '0;
            n_out.packet_error  = 1'b0;
            n_out.last          = 1'b1;
            if (r_second) begin
                n_out_valid   = 1'b1;
                n_out.tx_byte = cnlf_pkg::MSG_FLAG | {4'h0, r_code_nib};
                n_second      = 1'b0;
            end else if (!i_q_empty) begin
                o_q_rd      = 1'b1;
                n_out_valid = 1'b1;
                n_out.kind  = i_q_data.kind;
                case (i_q_data.kind)
                    cnlf_pkg::KIND_REQUEST: begin
                        n_out.tx_byte = {4'h0, i_q_data.addr};
                        n_out.last    = 1'b0;
                        n_second      = 1'b1;
                        n_code_nib    = i_q_data.code_nib;
                    end
                    cnlf_pkg::KIND_REPLY: begin
                        n_out.payload       = i_q_data.payload;
                        n_out.payload_bytes = i_q_data.nbytes;
                        n_out.packet_error  = i_q_data.err;
                    end
                    default: begin
                        n_out.kind = cnlf_pkg::KIND_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_code_nib <= n_code_nib;
    end

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_out_valid)
        else $error("second request byte pending without first");

    a_not_last_is_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_second && r_out.kind == cnlf_pkg::KIND_REQUEST))
        else $error("non-final result without pending second byte");

endmodule
`default_nettype wire

FILE: rtl/caliper_nibble_link_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caliper_nibble_link_framer
// Request framer and reply deframer for a nibble-coded sensor link.
// ----------------------------------------------------------------------------
// An item is taken in every cycle in which full is low. A start command yields
// two request-byte results, a completed reply or a rejected code yields one,
// and a received byte that does not complete a reply yields none. The first
// result of an item passes the record queue and the output register before it
// shows on the result ports. The single output register hands out one result
// per cycle while results are popped, so each start command takes it for two
// results; full rises when the two-entry record queue between the front and back
// ends holds two records. The configuration port is always ready.
// ----------------------------------------------------------------------------
module caliper_nibble_link_framer #(
    parameter int MAX_REPLY_BYTES = cnlf_pkg::CNLF_MAX_REPLY_BYTES,
    parameter int QUEUE_DEPTH     = cnlf_pkg::CNLF_QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire cnlf_pkg::t_item             i_item,
    output logic                             empty,
    input  wire logic                        pop,
    output cnlf_pkg::t_result                o_result,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [cnlf_pkg::ADDR_W-1:0] i_cfg_data
);

    logic            accept;
    logic            rec_valid;
    cnlf_pkg::t_rec  rec;
    logic            q_empty;
    logic            q_rd;
    cnlf_pkg::t_rec  q_data;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    cnlf_front #(
        .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    cnlf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rec_valid),
        .i_wr_data (rec),
        .i_rd      (q_rd),
        .o_full    (full),
        .o_empty   (q_empty),
        .o_rd_data (q_data)
    );

    cnlf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for caliper_nibble_link_framer. A directed table covers
// request codes, reply lengths, tag mismatches and abandoned receptions, then
// framed request/reply sequences with random content and noise run under
// several idling patterns and address settings. Every popped result is
// compared field by field with a typed table row or an in-bench framer model.
// ----------------------------------------------------------------------------
module testbench;
    import cnlf_pkg::*;

    localparam int DRAIN_PAUSE    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 375;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_item   stim;
        bit      typed;
        int      n_typed;
        t_result exp0;
        t_result exp1;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_item      i_item;
    logic       empty;
    logic       pop;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;

    caliper_nibble_link_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // framer model state
    logic [3:0]  dev_addr;
    bit          rx_active;
    int          reply_len;
    logic [3:0]  nib_idx;
    logic [2:0]  head_tag;
    bit          tag_bad;
    logic [63:0] reply_acc;

    t_result pending_results[$];
    int      fed_items;
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_req;
    int      quiet_cycles;
    t_row    plan[$];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic t_item stim(logic cmd, logic [7:0] code, logic [7:0] rx);
        t_item it;
        it.command  = cmd;
        it.req_code = code;
        it.rx_byte  = rx;
        return it;
    endfunction

    function automatic t_result res(t_kind k, logic [7:0] tx, logic [63:0] pl,
                                    logic [3:0] nb, logic er, logic lst);
        t_result r;
        r.kind          = k;
        r.tx_byte       = tx;
        r.payload       = pl;
        r.payload_bytes = nb;
        r.packet_error  = er;
        r.last          = lst;
        return r;
    endfunction

    function automatic t_row plain(t_item it);
        t_row r;
        r.stim    = it;
        r.typed   = 1'b0;
        r.n_typed = 0;
        r.exp0    = '0;
        r.exp1    = '0;
        return r;
    endfunction

    function automatic t_row typed_row(t_item it, int n, t_result e0, t_result e1);
        t_row r;
        r.stim    = it;
        r.typed   = 1'b1;
        r.n_typed = n;
        r.exp0    = e0;
        r.exp1    = e1;
        return r;
    endfunction

    function automatic bit frame_predict(input t_item it, ref t_result outs[$]);
        logic [2:0] tag;
        if (it.command == CMD_START) begin
            if (it.req_code == CODE_IDENTIFY || it.req_code == CODE_MEASURE) begin
                reply_len = (it.req_code == CODE_IDENTIFY) ? LEN_IDENTIFY : LEN_MEASURE;
                if (reply_len > CNLF_MAX_REPLY_BYTES) begin
                    reply_len = CNLF_MAX_REPLY_BYTES;
                end
                rx_active = 1'b1;
                nib_idx   = '0;
                head_tag  = '0;
                tag_bad   = 1'b0;
                reply_acc = '0;
                outs.push_back(res(KIND_REQUEST, {4'h0, dev_addr}, '0, '0, 1'b0, 1'b0));
                outs.push_back(res(KIND_REQUEST, MSG_FLAG | {4'h0, it.req_code[3:0]},
                                   '0, '0, 1'b0, 1'b1));
            end else begin
                rx_active = 1'b0;
                outs.push_back(res(KIND_REJECT, '0, '0, '0, 1'b0, 1'b1));
            end
            return 1'b1;
        end
        if (!rx_active) begin
            return 1'b0;
        end
        tag = it.rx_byte[6:4];
        if (nib_idx == 0) begin
            head_tag = tag;
        end else if (tag != head_tag) begin
            tag_bad = 1'b1;
        end
        reply_acc[4*nib_idx +: 4] = it.rx_byte[3:0];
        if (int'(nib_idx) + 1 >= 2 * reply_len) begin
            outs.push_back(res(KIND_REPLY, '0, reply_acc, 4'(reply_len), tag_bad, 1'b1));
            rx_active = 1'b0;
            nib_idx   = '0;
        end else begin
            nib_idx = nib_idx + 4'd1;
        end
        return 1'b1;
    endfunction

    task automatic offer_item(input t_row r);
        t_result fresh[$];
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= r.stim;
        do @(posedge i_clk); while (full);
        if (frame_predict(r.stim, fresh)) begin
            fed_items++;
        end
        if (r.typed) begin
            fresh.delete();
            if (r.n_typed > 0) fresh.push_back(r.exp0);
            if (r.n_typed > 1) fresh.push_back(r.exp1);
        end
        foreach (fresh[i]) begin
            pending_results.push_back(fresh[i]);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [3:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dev_addr = addr;
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("unexpected result: kind=%0d tx=%02h payload=%016h",
                         got.kind, got.tx_byte, got.payload);
                $display("          bytes=%0d err=%0d last=%0d",
                         got.payload_bytes, got.packet_error, got.last);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.tx_byte !== want.tx_byte
                || got.payload !== want.payload || got.payload_bytes !== want.payload_bytes
                || got.packet_error !== want.packet_error || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch: expected kind=%0d tx=%02h payload=%016h bytes=%0d %s",
                         want.kind, want.tx_byte, want.payload, want.payload_bytes,
                         $sformatf("err=%0d last=%0d", want.packet_error, want.last));
                $display("          actual   kind=%0d tx=%02h payload=%016h bytes=%0d %s",
                         got.kind, got.tx_byte, got.payload, got.payload_bytes,
                         $sformatf("err=%0d last=%0d", got.packet_error, got.last));
            end
        end
    endtask

    task automatic feed_random(input int quota);
        int         base;
        int         pick;
        int         nbytes;
        int         cut;
        int         bad_at;
        logic [2:0] tag;
        logic [7:0] rx;
        logic [7:0] code;
        base = fed_items;
        while (fed_items - base < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                code = $urandom_range(1) ? CODE_IDENTIFY : CODE_MEASURE;
                offer_item(plain(stim(CMD_START, code, 8'($urandom))));
                nbytes = 2 * ((code == CODE_IDENTIFY) ? LEN_IDENTIFY : LEN_MEASURE);
                cut    = ($urandom_range(9) == 0) ? $urandom_range(nbytes - 1) : nbytes;
                bad_at = ($urandom_range(3) == 0) ? $urandom_range(nbytes - 1, 1) : -1;
                tag    = 3'($urandom);
                for (int k = 0; k < cut; k++) begin
                    rx      = 8'($urandom);
                    rx[6:4] = (k == bad_at) ? tag ^ 3'($urandom_range(7, 1)) : tag;
                    offer_item(plain(stim(CMD_BYTE, 8'($urandom), rx)));
                end
            end else if (pick < 92) begin
                offer_item(plain(stim(CMD_START, 8'($urandom), 8'($urandom))));
            end else begin
                offer_item(plain(stim(CMD_BYTE, 8'($urandom), 8'($urandom))));
            end
        end
    endtask

    // receive side
    initial begin
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                check_result(o_result);
            end
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL caliper_nibble_link_framer");
            $finish;
        end
    end

    initial begin
        logic [3:0] addr;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_item         <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        dev_addr       = '0;
        rx_active      = 1'b0;
        reply_len      = 0;
        nib_idx        = '0;
        head_tag       = '0;
        tag_bad        = 1'b0;
        reply_acc      = '0;
        fed_items      = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;

        plan.push_back(typed_row(stim(CMD_BYTE, 8'h00, 8'hFF), 0, '0, '0));
        plan.push_back(typed_row(stim(CMD_START, CODE_MEASURE, 8'hFF), 2,
                                 res(KIND_REQUEST, 8'h00, '0, '0, 1'b0, 1'b0),
                                 res(KIND_REQUEST, 8'h86, '0, '0, 1'b0, 1'b1)));
        plan.push_back(plain(stim(CMD_BYTE, 8'hFF, 8'hFF)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h70)));
        plan.push_back(plain(stim(CMD_BYTE, 8'hFF, 8'hF0)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h7F)));
        plan.push_back(plain(stim(CMD_BYTE, 8'hA5, 8'h75)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h5A, 8'hFA)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h73)));
        plan.push_back(plain(stim(CMD_BYTE, 8'hFF, 8'hFC)));
        plan.push_back(typed_row(stim(CMD_START, CODE_IDENTIFY, 8'h00), 2,
                                 res(KIND_REQUEST, 8'h00, '0, '0, 1'b0, 1'b0),
                                 res(KIND_REQUEST, 8'h81, '0, '0, 1'b0, 1'b1)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h21)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h32)));
        plan.push_back(typed_row(stim(CMD_START, CODE_MEASURE, 8'h00), 2,
                                 res(KIND_REQUEST, 8'h00, '0, '0, 1'b0, 1'b0),
                                 res(KIND_REQUEST, 8'h86, '0, '0, 1'b0, 1'b1)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h44)));
        plan.push_back(typed_row(stim(CMD_START, 8'h00, 8'h00), 1,
                                 res(KIND_REJECT, 8'h00, '0, '0, 1'b0, 1'b1), '0));
        plan.push_back(typed_row(stim(CMD_START, 8'hFF, 8'hFF), 1,
                                 res(KIND_REJECT, 8'h00, '0, '0, 1'b0, 1'b1), '0));
        plan.push_back(typed_row(stim(CMD_START, CODE_MEASURE, 8'h00), 2,
                                 res(KIND_REQUEST, 8'h00, '0, '0, 1'b0, 1'b0),
                                 res(KIND_REQUEST, 8'h86, '0, '0, 1'b0, 1'b1)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h0F)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h00)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h5C)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h07)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h08)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h09)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h0A)));
        plan.push_back(plain(stim(CMD_BYTE, 8'h00, 8'h8B)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            offer_item(plan[i]);
        end

        for (int p = 0; p < 4; p++) begin
            drain_results();
            addr = (p == 0) ? 4'hF : (p == 2) ? 4'h0 : 4'($urandom);
            write_address(addr);
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 87 : 26) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 87 : 26) : 0;
            if (p == 0) begin
                hold_req = 1'b1;
            end
            feed_random(PHASE_ITEMS);
        end

        drain_results();
        repeat (2 * DRAIN_PAUSE) @(posedge i_clk);
        mismatches += pending_results.size();
        if (mismatches == 0) begin
            $display("PASS caliper_nibble_link_framer");
        end else begin
            $display("FAIL caliper_nibble_link_framer");
        end
        $finish;
    end

endmodule
